/* src/dds_pkg.sv */
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and fixed widths for the incoherent dedispersion summer.
// ----------------------------------------------------------------------------
package dds_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CHAN_W   = 8;
  localparam int TRIAL_W  = 6;
  localparam int TIME_W   = 16;
  localparam int SUM_W    = 24;
  localparam int CFG_W    = 32;
  localparam int SLEN_W   = 17;
  localparam int CUSE_W   = 9;
  localparam int CIDX_W   = 3;

  // Delay arithmetic widths: trial DM, frequency magnitude, f^2, denominator, numerator, DM shift
  localparam int DM_W     = 38;
  localparam int FU_W     = 22;
  localparam int SQ_W     = 44;
  localparam int DEN_W    = 61;
  localparam int NUM_W    = 62;
  localparam int DM_SHIFT = 17;

  // 1/0.00001 scale applied to f^2
  localparam logic [16:0] DEN_SCALE = 17'd100000;

  // Saturation limits of the output sum
  localparam logic signed [31:0] SUM_MAX = 32'sd8388607;
  localparam logic signed [31:0] SUM_MIN = -32'sd8388608;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_FREQ_BOTTOM   = 3'd0,
    CFG_CHANNEL_WIDTH = 3'd1,
    CFG_DM_STEP       = 3'd2,
    CFG_DM_START      = 3'd3,
    CFG_SERIES_LENGTH = 3'd4,
    CFG_CHANNELS_USED = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0]          channel_number;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       slice_end;
  } in_beat_t;

  typedef struct packed {
    logic [TRIAL_W-1:0]      trial_number;
    logic [TIME_W-1:0]       time_number;
    logic signed [SUM_W-1:0] dedispersed_sum;
    logic                    run_end;
  } out_beat_t;

  // Request into the delay unit
  typedef struct packed {
    logic            start;
    logic            nonpos;  // frequency <= 0
    logic            big;     // frequency >= 64.0
    logic [DM_W-1:0] dm;
    logic [FU_W-1:0] fu;
  } dly_req_t;

endpackage

/* src/dds_ring.sv */
// ----------------------------------------------------------------------------
// dds_ring
// Per-channel sample history, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dds_ring
  import dds_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dds_delay.sv */
// ----------------------------------------------------------------------------
// dds_delay
// Iterative delay unit: round(DM*2^16 / (100000*f^2)) saturated at the
// ring length minus one, via square, scale and a restoring divide.
// ----------------------------------------------------------------------------
module dds_delay
  import dds_pkg::*;
#(
  parameter int MAX_DELAY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dly_req_t                      req_i,
  output logic                          done_o,
  output logic [$clog2(MAX_DELAY)-1:0]  delay_o
);

  localparam int DW    = $clog2(MAX_DELAY);
  localparam int DSH_W = NUM_W + DW;
  localparam int CNT_W = $clog2(DW + 1);
  localparam logic [DW-1:0] LIM = DW'(MAX_DELAY - 1);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_SQ   = 5'b00010,
    D_DEN  = 5'b00100,
    D_PREP = 5'b01000,
    D_DIV  = 5'b10000
  } dstate_e;

  dstate_e           state_q;
  logic [DM_W-1:0]   dm_q;
  logic [FU_W-1:0]   fu_q;
  logic [SQ_W-1:0]   sq_q;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  rem_q;
  logic [DSH_W-1:0]  dsh_q;
  logic [DW-1:0]     quo_q;
  logic [CNT_W-1:0]  step_q;
  logic [DW-1:0]     delay_q;
  logic              done_q;

  logic              ge;
  logic [DW-1:0]     quo_fin;

  // one compare per divide step
  assign ge      = ({{DW{1'b0}}, rem_q} >= dsh_q);
  assign quo_fin = (quo_q << 1) | DW'(ge);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            if (req_i.nonpos) begin
              delay_q <= LIM;
              done_q  <= 1'b1;
            end else if (req_i.big) begin
              delay_q <= '0;
              done_q  <= 1'b1;
            end else begin
              dm_q    <= req_i.dm;
              fu_q    <= req_i.fu;
              state_q <= D_SQ;
            end
          end
        end
        D_SQ: begin
          sq_q    <= SQ_W'(fu_q) * SQ_W'(fu_q);
          state_q <= D_DEN;
        end
        D_DEN: begin
          den_q   <= DEN_W'(sq_q) * DEN_W'(DEN_SCALE);
          state_q <= D_PREP;
        end
        D_PREP: begin
          // numerator 2*DM*2^16 + den, divisor 2*den aligned to the top bit
          rem_q   <= NUM_W'({dm_q, {DM_SHIFT{1'b0}}}) + NUM_W'(den_q);
          dsh_q   <= DSH_W'({den_q, 1'b0}) << DW;
          quo_q   <= '0;
          step_q  <= '0;
          state_q <= D_DIV;
        end
        D_DIV: begin
          dsh_q <= dsh_q >> 1;
          if (step_q == '0) begin
            // quotient past the top bit: saturate
            if (ge) begin
              delay_q <= LIM;
              done_q  <= 1'b1;
              state_q <= D_IDLE;
            end else begin
              step_q <= step_q + CNT_W'(1);
            end
          end else begin
            if (ge) begin
              rem_q <= rem_q - dsh_q[NUM_W-1:0];
            end
            quo_q <= quo_fin;
            if (step_q == CNT_W'(DW)) begin
              delay_q <= (quo_fin > LIM) ? LIM : quo_fin;
              done_q  <= 1'b1;
              state_q <= D_IDLE;
            end else begin
              step_q <= step_q + CNT_W'(1);
            end
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign delay_o = delay_q;

endmodule

/* src/incoherent_dedispersion_sum.sv */
// A beat without slice_end, or one before the window fills, is taken without stalling.
// A completing slice runs NUM_DM trials, each with one delay request and one ring read
// per channel in use, through the single shared delay divider; emission waits on out_stall_i.
// Each completing slice yields one dedispersed sum per trial; input stalls during the run.
// Reset: control state and configuration return to defaults; the ring is not
// cleared, so a slot that no beat has written reads undefined contents.
// ----------------------------------------------------------------------------
// incoherent_dedispersion_sum
// Direct incoherent dedispersion: history ring plus sequenced per-trial sums.
// ----------------------------------------------------------------------------
module incoherent_dedispersion_sum
  import dds_pkg::*;
#(
  parameter int NUM_CHAN    = 256,
  parameter int MAX_DELAY   = 64,
  parameter int NUM_DM      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int DW    = $clog2(MAX_DELAY);
  localparam int DEPTH = NUM_CHAN * MAX_DELAY;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(NUM_CHAN + 1);
  localparam int FW    = CFG_W + $clog2(NUM_CHAN) + 2;
  localparam int ACC_W = SAMPLE_W + $clog2(NUM_CHAN) + 1;
  localparam int SS_W  = $clog2(MAX_DELAY + 1);
  localparam int SU    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [DW-1:0]      LIM     = DW'(MAX_DELAY - 1);
  localparam logic signed [FW-1:0] F_BIG = FW'(1) << FU_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TRIAL = 6'b000010,
    S_REQ   = 6'b000100,
    S_WAIT  = 6'b001000,
    S_ACC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  // configuration
  logic [CFG_W-1:0]  freq_bottom_q;
  logic [CFG_W-1:0]  channel_width_q;
  logic [CFG_W-1:0]  dm_step_q;
  logic [CFG_W-1:0]  dm_start_q;
  logic [SLEN_W-1:0] series_length_q;
  logic [CUSE_W-1:0] channels_in_use_q;

  // control and datapath state
  state_e                  state_q;
  logic [DW-1:0]           ring_pos_q;
  logic [SS_W-1:0]         seen_q;
  logic [TIME_W-1:0]       time_q;
  logic [DW-1:0]           oldest_q;
  logic [TRIAL_W-1:0]      k_q;
  logic [DM_W-1:0]         dm_q;
  logic [CW-1:0]           c_q;
  logic [CW-1:0]           used_q;
  logic signed [FW-1:0]    f_q;
  logic [AW-1:0]           base_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    out_valid_q;
  out_beat_t               out_q;

  logic                    in_acc;
  logic                    ring_we;
  logic [AW-1:0]           ring_waddr;
  logic signed [SAMPLE_W-1:0] samp;
  logic                    ring_re;
  logic [AW-1:0]           ring_raddr;
  logic [SAMPLE_W-1:0]     ring_rdata;
  dly_req_t                dly_req;
  logic                    dly_done;
  logic [DW-1:0]           dly_val;
  logic [DW:0]             slot_sum;
  logic [DW-1:0]           slot;
  logic [SS_W-1:0]         seen_nx;
  logic                    emit_go;
  logic signed [31:0]      acc32;
  logic signed [SUM_W-1:0] sum_sat;
  logic [SLEN_W-1:0]       time_inc;
  logic                    time_wrap;
  logic [DW-1:0]           pos_inc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & ~in_stall_o;

  // ring write of the incoming sample
  assign samp       = SAMPLE_W'(signed'(in_data_i.sample_value[SU-1:0]));
  assign ring_we    = in_acc && (32'(in_data_i.channel_number) < NUM_CHAN);
  assign ring_waddr = AW'(32'(in_data_i.channel_number) * MAX_DELAY + 32'(ring_pos_q));

  // slot of the delayed sample, one wrap at most
  assign slot_sum   = {1'b0, oldest_q} + {1'b0, dly_val};
  assign slot       = (32'(slot_sum) >= MAX_DELAY) ? DW'(32'(slot_sum) - MAX_DELAY)
                                                   : slot_sum[DW-1:0];
  assign ring_re    = (state_q == S_WAIT) && dly_done;
  assign ring_raddr = base_q + AW'(slot);

  // delay request from the current frequency
  always_comb begin
    dly_req        = '0;
    dly_req.start  = (state_q == S_REQ);
    dly_req.nonpos = (f_q <= 0);
    dly_req.big    = (f_q >= F_BIG);
    dly_req.dm     = dm_q;
    dly_req.fu     = f_q[FU_W-1:0];
  end

  // misc next-value helpers
  assign seen_nx   = (32'(seen_q) < MAX_DELAY) ? seen_q + SS_W'(1) : seen_q;
  assign pos_inc   = (ring_pos_q == LIM) ? '0 : ring_pos_q + DW'(1);
  assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign acc32     = 32'(acc_q);
  assign sum_sat   = (acc32 > SUM_MAX) ? SUM_W'(SUM_MAX) :
                     (acc32 < SUM_MIN) ? SUM_W'(SUM_MIN) : SUM_W'(acc32);
  assign time_inc  = {1'b0, time_q} + SLEN_W'(1);
  assign time_wrap = (series_length_q == '0 || series_length_q > SLEN_W'(65536))
                     ? time_inc[TIME_W] : (time_inc >= series_length_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_bottom_q     <= 32'd85196800;
      channel_width_q   <= 32'd65536;
      dm_step_q         <= 32'd65536;
      dm_start_q        <= '0;
      series_length_q   <= 17'd4096;
      channels_in_use_q <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FREQ_BOTTOM:   freq_bottom_q     <= cfg_data_i;
        CFG_CHANNEL_WIDTH: channel_width_q   <= cfg_data_i;
        CFG_DM_STEP:       dm_step_q         <= cfg_data_i;
        CFG_DM_START:      dm_start_q        <= cfg_data_i;
        CFG_SERIES_LENGTH: series_length_q   <= cfg_data_i[SLEN_W-1:0];
        CFG_CHANNELS_USED: channels_in_use_q <= cfg_data_i[CUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: trials outer, channels inner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_pos_q  <= '0;
      seen_q      <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result beat taken and no new one loaded this cycle
      if (out_valid_q && !out_stall_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_data_i.slice_end) begin
            seen_q <= seen_nx;
            if (32'(seen_nx) >= MAX_DELAY) begin
              oldest_q <= pos_inc;
              k_q      <= '0;
              dm_q     <= DM_W'(dm_start_q);
              used_q   <= (32'(channels_in_use_q) > NUM_CHAN) ? CW'(NUM_CHAN)
                                                             : CW'(channels_in_use_q);
              state_q  <= S_TRIAL;
            end else begin
              ring_pos_q <= pos_inc;
            end
          end
        end
        S_TRIAL: begin
          c_q    <= '0;
          f_q    <= FW'(signed'({1'b0, freq_bottom_q}));
          base_q <= '0;
          acc_q  <= '0;
          state_q <= (used_q == '0) ? S_EMIT : S_REQ;
        end
        S_REQ: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (dly_done) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          acc_q  <= acc_q + ACC_W'(signed'(ring_rdata));
          c_q    <= c_q + CW'(1);
          f_q    <= f_q + FW'(signed'(channel_width_q));
          base_q <= base_q + AW'(MAX_DELAY);
          state_q <= (c_q + CW'(1) == used_q) ? S_EMIT : S_REQ;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_q           <= 1'b1;
            out_q.trial_number    <= k_q;
            out_q.time_number     <= time_q;
            out_q.dedispersed_sum <= sum_sat;
            out_q.run_end         <= (k_q == TRIAL_W'(NUM_DM - 1));
            if (k_q == TRIAL_W'(NUM_DM - 1)) begin
              time_q     <= time_wrap ? '0 : time_inc[TIME_W-1:0];
              ring_pos_q <= pos_inc;
              state_q    <= S_IDLE;
            end else begin
              k_q     <= k_q + TRIAL_W'(1);
              dm_q    <= dm_q + DM_W'(dm_step_q);
              state_q <= S_TRIAL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  dds_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (samp),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  dds_delay #(
    .MAX_DELAY (MAX_DELAY)
  ) u_delay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dly_req),
    .done_o  (dly_done),
    .delay_o (dly_val)
  );

endmodule

/* src/dds_checker.sv */
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks for the dedispersion summer, bound to the top level.
// ----------------------------------------------------------------------------
module dds_checker
  import dds_pkg::*;
#(
  parameter int NUM_DM = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input in_beat_t          in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input out_beat_t         out_data_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed under stall");

  // run_end marks exactly the last trial
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.run_end == (out_data_o.trial_number == TRIAL_W'(NUM_DM - 1))))
    else $error("run_end does not match last trial");

  // a mid-slice beat never starts a run
  a_mid_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.slice_end |=> !in_stall_o)
    else $error("busy after mid-slice beat");

  // results are only produced while a run holds off input
  a_out_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared outside a run");

endmodule

bind incoherent_dedispersion_sum dds_checker #(.NUM_DM(NUM_DM)) u_dds_checker (.*);

/* test/dds_sum_checker.sv */
// ----------------------------------------------------------------------------
// dds_sum_checker
// Watches the sample, sum and register channels of the dedispersion summer.
// Keeps its own history ring and register copies. For every accepted sample
// beat it computes the sums that the beat must produce and queues them. Every
// accepted sum beat is compared field by field with the oldest queued sum.
// ----------------------------------------------------------------------------
module dds_sum_checker
  import dds_pkg::*;
#(
  parameter int NUM_CHAN  = 256,
  parameter int MAX_DELAY = 64,
  parameter int NUM_DM    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_beat_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_beat_t         out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output int                errors_o,
  output int                pending_o
);

  // Register copies
  logic [31:0]       freq_bottom_q;
  logic signed [31:0] chan_width_q;
  logic [31:0]       dm_step_q;
  logic [31:0]       dm_start_q;
  logic [16:0]       series_len_q;
  logic [8:0]        chans_used_q;

  // Window state
  logic signed [SAMPLE_W-1:0] ring_mem [0:NUM_CHAN*MAX_DELAY-1];
  int unsigned slot_pos;
  int unsigned slices_filled;
  int unsigned time_idx;

  out_beat_t sum_queue[$];
  int        mismatches;

  assign errors_o  = mismatches;
  assign pending_o = sum_queue.size();

  // Slices of delay for one trial DM at one channel frequency
  function automatic int unsigned delay_slices(longint unsigned dm, longint freq);
    longint unsigned fu, den, q;
    if (freq <= 0) return MAX_DELAY - 1;
    fu = longint'(freq);
    if (fu >= (64'd1 << 22)) return 0;
    den = 64'd100000 * fu * fu;
    q = (2 * (dm << 16) + den) / (2 * den);
    return (q > MAX_DELAY - 1) ? MAX_DELAY - 1 : int'(q);
  endfunction

  // Store one sample; on a completed full window queue one sum per trial
  task automatic absorb_sample(in_beat_t b);
    int unsigned used, oldest, slot, eff_len;
    longint unsigned dm;
    longint freq, acc;
    out_beat_t r;
    ring_mem[b.channel_number * MAX_DELAY + slot_pos] = b.sample_value;
    if (!b.slice_end) return;
    if (slices_filled < MAX_DELAY) slices_filled++;
    if (slices_filled >= MAX_DELAY) begin
      used   = (chans_used_q < NUM_CHAN) ? chans_used_q : NUM_CHAN;
      oldest = (slot_pos + 1) % MAX_DELAY;
      for (int k = 0; k < NUM_DM; k++) begin
        dm  = longint'(dm_start_q) + longint'(dm_step_q) * k;
        acc = 0;
        for (int c = 0; c < used; c++) begin
          freq = longint'(freq_bottom_q) + longint'(c) * longint'(chan_width_q);
          slot = (oldest + delay_slices(dm, freq)) % MAX_DELAY;
          acc += ring_mem[c * MAX_DELAY + slot];
        end
        if (acc > SUM_MAX) acc = SUM_MAX;
        if (acc < SUM_MIN) acc = SUM_MIN;
        r.trial_number    = k[TRIAL_W-1:0];
        r.time_number     = time_idx[TIME_W-1:0];
        r.dedispersed_sum = acc[SUM_W-1:0];
        r.run_end         = (k == NUM_DM - 1);
        sum_queue.push_back(r);
      end
      eff_len = (series_len_q == 0 || series_len_q > 65536) ? 65536 : series_len_q;
      time_idx = time_idx + 1;
      if (time_idx >= eff_len) time_idx = 0;
      time_idx &= 32'hFFFF;
    end
    slot_pos = (slot_pos + 1) % MAX_DELAY;
  endtask

  task automatic compare_sum(out_beat_t got);
    out_beat_t exp_b;
    if (sum_queue.size() == 0) begin
      $display("%0t: unexpected sum beat %h", $time, got);
      mismatches++;
      return;
    end
    exp_b = sum_queue.pop_front();
    if (got.trial_number !== exp_b.trial_number) begin
      $display("%0t: trial_number expected %0d actual %0d", $time,
               exp_b.trial_number, got.trial_number);
      mismatches++;
    end
    if (got.time_number !== exp_b.time_number) begin
      $display("%0t: time_number expected %0d actual %0d", $time,
               exp_b.time_number, got.time_number);
      mismatches++;
    end
    if (got.dedispersed_sum !== exp_b.dedispersed_sum) begin
      $display("%0t: dedispersed_sum expected %0d actual %0d (trial %0d)", $time,
               exp_b.dedispersed_sum, got.dedispersed_sum, exp_b.trial_number);
      mismatches++;
    end
    if (got.run_end !== exp_b.run_end) begin
      $display("%0t: run_end expected %0b actual %0b", $time,
               exp_b.run_end, got.run_end);
      mismatches++;
    end
  endtask

  // Sample all three channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_bottom_q <= 32'd85196800;
      chan_width_q  <= 32'sd65536;
      dm_step_q     <= 32'd65536;
      dm_start_q    <= '0;
      series_len_q  <= 17'd4096;
      chans_used_q  <= 9'd256;
      slot_pos      = 0;
      slices_filled = 0;
      time_idx      = 0;
      mismatches    = 0;
      sum_queue.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_sum(out_data_i);
      if (in_valid_i && !in_stall_i) absorb_sample(in_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FREQ_BOTTOM:   freq_bottom_q <= cfg_data_i;
          CFG_CHANNEL_WIDTH: chan_width_q  <= cfg_data_i;
          CFG_DM_STEP:       dm_step_q     <= cfg_data_i;
          CFG_DM_START:      dm_start_q    <= cfg_data_i;
          CFG_SERIES_LENGTH: series_len_q  <= cfg_data_i[SLEN_W-1:0];
          CFG_CHANNELS_USED: chans_used_q  <= cfg_data_i[CUSE_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/tb_incoherent_dedispersion_sum.sv */
// ----------------------------------------------------------------------------
// tb_incoherent_dedispersion_sum
// Fills the history window, then runs directed and random slices under several
// register settings with random idling on both sides. The checker beside the
// block predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_incoherent_dedispersion_sum;
  import dds_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int STALL_LIMIT = 8000;
  localparam int FILL_CHANS  = 3;   // channels written in every well-formed slice

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_beat_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  int                errors, pending;

  bit quiet = 1'b0;        // no idling on either side
  int hold_request = 0;    // receiver hold-off length, picked up by receiver
  int beats_sent = 0;

  always #HALF_PERIOD clk = ~clk;

  incoherent_dedispersion_sum dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  dds_sum_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 29);
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    int idle_cycles;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one sample beat; called and returns at a falling edge
  task automatic send_sample(int ch, int val, bit last);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{channel_number: ch[CHAN_W-1:0], sample_value: val[SAMPLE_W-1:0],
                  slice_end: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
  endtask

  // Stop sending and wait for every queued sum plus the block's tail
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] fb, logic [31:0] cw, logic [31:0] step,
                          logic [31:0] start, logic [31:0] slen, logic [31:0] used);
    write_reg(CFG_FREQ_BOTTOM, fb);
    write_reg(CFG_CHANNEL_WIDTH, cw);
    write_reg(CFG_DM_STEP, step);
    write_reg(CFG_DM_START, start);
    write_reg(CFG_SERIES_LENGTH, slen);
    write_reg(CFG_CHANNELS_USED, used);
  endtask

  // Well-formed slice over the filled channels, maybe with a stray high channel
  task automatic send_slice;
    bit extra;
    extra = ($urandom_range(3) == 0);
    for (int c = 0; c < FILL_CHANS; c++)
      send_sample(c, $urandom, (c == FILL_CHANS - 1) && !extra);
    if (extra) send_sample($urandom_range(255, FILL_CHANS), $urandom, 1'b1);
  endtask

  // Broken slice: missing channels, random order and flags
  task automatic send_noise;
    int n;
    n = $urandom_range(3, 1);
    for (int i = 0; i < n; i++)
      send_sample($urandom_range(255), $urandom, (i == n - 1) || $urandom_range(1));
  endtask

  task automatic random_regs;
    logic [31:0] fb, slen;
    case ($urandom_range(2))
      0: fb = $urandom_range(20000, 1);
      1: fb = $urandom_range(400000, 20000);
      default: fb = $urandom;
    endcase
    case ($urandom_range(3))
      0: slen = $urandom_range(3, 1);
      1: slen = 0;
      default: slen = $urandom_range(131071);
    endcase
    set_regs(fb, $urandom_range(1) ? $urandom : $urandom_range(4000),
             $urandom, $urandom_range(1) ? $urandom : $urandom_range(65536),
             slen, $urandom_range(FILL_CHANS));
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Window fill: no sums until MAX_DELAY slices, so a wide channel count is safe
    set_regs(32'd85196800, 32'sd65536, 32'd65536, 32'd0, 32'd4096, 32'd256);
    for (int s = 0; s < 63; s++) begin
      for (int c = 0; c < FILL_CHANS; c++)
        send_sample(c, $urandom, (c == FILL_CHANS - 1) && (s != 10));
      if (s == 10) send_sample(255, 16'h5555, 1'b1);
    end
    drain();

    // Directed: tiny frequencies, single-slice series, sample extremes
    set_regs(32'h0000_0290, 32'h0000_0100, 32'h0001_0000, 32'd0, 32'd1, 32'd3);
    send_sample(0, 32767, 0); send_sample(1, -32768, 0); send_sample(2, 0, 1);
    send_sample(0, -1, 0); send_sample(2, 1, 1);               // channel 1 missing
    send_sample(0, 16'hAAAA, 0); send_sample(1, 16'h5555, 0);
    send_sample(2, -32768, 0); send_sample(255, 32767, 1);     // top channel ends slice
    send_sample(1, 12345, 1);                                  // lone channel
    send_sample(2, -7, 0); send_sample(1, 7, 0); send_sample(0, 3, 1);  // out of order
    drain();
    // Nonpositive frequency everywhere, largest DMs, no channels summed
    set_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65536, 32'd0);
    send_slice();
    drain();
    set_regs(32'd0, 32'h0000_0800, 32'hFFFF_FFFF, 32'd0, 32'd65536, 32'd3);
    send_slice(); send_slice();
    drain();
    // Frequency above the delay range, most negative channel width, length 0
    set_regs(32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd2);
    send_slice();
    drain();
    set_regs(32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_8000, 32'h0001_0000,
             32'd131071, 32'd3);
    send_slice();
    drain();

    // Random phases
    for (int ph = 0; ph < 6; ph++) begin
      int stop_at;
      random_regs();
      quiet   = (ph == 2);
      stop_at = beats_sent + 8;
      // long receiver hold-off while the sender keeps offering
      if (ph == 0) hold_request = 400;
      while (beats_sent < stop_at) begin
        if ($urandom_range(99) < 80) send_slice();
        else send_noise();
      end
      drain();
    end
    quiet = 1'b0;

    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/dds_pkg.sv
src/dds_ring.sv
src/dds_delay.sv
src/incoherent_dedispersion_sum.sv
src/dds_checker.sv
test/dds_sum_checker.sv
test/tb_incoherent_dedispersion_sum.sv
